@@ rtl/owdm_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// owdm_pkg
// Shared types, constants and helpers for the omni wheel drive mixer.
// ----------------------------------------------------------------------------
package owdm_pkg;

    localparam int AXIS_COUNT  = 3;
    localparam int WHEEL_COUNT = 3;

    localparam int STICK_W = 16;
    localparam int DZ_W    = 15;
    localparam int COEF_W  = 10;
    localparam int ROW_W   = 3 * COEF_W;
    localparam int AXIS_W  = 9;
    localparam int DUTY_W  = 8;
    localparam int NUM_W   = 24;
    localparam int PROD_W  = COEF_W + AXIS_W;
    localparam int SUM_W   = PROD_W + 2;

    localparam int LANE_STAGES = 7;
    localparam int MIX_STAGES  = 3;
    localparam int PIPE_STAGES = LANE_STAGES + MIX_STAGES;

    localparam logic [DZ_W-1:0]   AXIS_FULL = 15'h7FFF;
    localparam logic [DUTY_W-1:0] DUTY_MAX  = 8'd255;

    localparam logic [1:0] REG_DEAD_ZONE  = 2'd0;
    localparam logic [1:0] REG_WHEEL1_ROW = 2'd1;
    localparam logic [1:0] REG_WHEEL2_ROW = 2'd2;
    localparam logic [1:0] REG_WHEEL3_ROW = 2'd3;

    localparam logic [DZ_W-1:0]  DEAD_ZONE_RESET  = 15'd7500;
    localparam logic [ROW_W-1:0] WHEEL1_ROW_RESET = 30'd89043092;
    localparam logic [ROW_W-1:0] WHEEL2_ROW_RESET = 30'd89043820;
    localparam logic [ROW_W-1:0] WHEEL3_ROW_RESET = 30'd88256512;

    typedef logic signed [AXIS_W-1:0] axis_t;
    typedef logic [ROW_W-1:0]         row_t;

    typedef struct packed {
        logic [NUM_W-1:0] rem;
        logic [1:0]       q;
    } div_step_t;

    // Two restoring division steps producing quotient bits sh and sh-1.
    function automatic div_step_t div_step2(input logic [NUM_W-1:0] rem,
                                            input logic [DZ_W-1:0] den,
                                            input int unsigned sh);
        div_step_t        r;
        logic [NUM_W-1:0] d_hi;
        logic [NUM_W-1:0] d_lo;
        d_hi  = {{(NUM_W-DZ_W){1'b0}}, den} << sh;
        d_lo  = {{(NUM_W-DZ_W){1'b0}}, den} << (sh - 1);
        r.rem = rem;
        r.q   = 2'b00;
        if (r.rem >= d_hi) begin
            r.rem  = r.rem - d_hi;
            r.q[1] = 1'b1;
        end
        if (r.rem >= d_lo) begin
            r.rem  = r.rem - d_lo;
            r.q[0] = 1'b1;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

@@ rtl/owdm_axis_lane.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// owdm_axis_lane
// Dead zone and linear rescale of one stick axis onto -255..255 through a
// pipelined restoring divider.
// ----------------------------------------------------------------------------
module owdm_axis_lane (
    input  wire logic                                  aclk,
    input  wire logic [owdm_pkg::LANE_STAGES-1:0]      stage_en,
    input  wire logic [owdm_pkg::DZ_W-1:0]             dead_zone,
    input  wire logic signed [owdm_pkg::STICK_W-1:0]   stick,
    output owdm_pkg::axis_t                            axis_value
);

    logic signed [owdm_pkg::STICK_W:0] x_ext;
    logic signed [owdm_pkg::STICK_W:0] dz_ext;
    logic signed [owdm_pkg::STICK_W:0] mag_s;
    logic                              is_pos;
    logic                              is_neg;
    logic [owdm_pkg::DZ_W-1:0]         den;
    logic [owdm_pkg::NUM_W-1:0]        num_next;
    owdm_pkg::div_step_t               step3;
    owdm_pkg::div_step_t               step4;
    owdm_pkg::div_step_t               step5;
    owdm_pkg::div_step_t               step6;
    logic [owdm_pkg::DUTY_W-1:0]       mag_final;

    logic [owdm_pkg::STICK_W-1:0] mag0_reg;
    logic                         neg0_reg;
    logic [owdm_pkg::NUM_W-1:0]   num1_reg;
    logic                         neg1_reg;
    logic [owdm_pkg::NUM_W-1:0]   rem2_reg;
    logic                         ovf2_reg;
    logic                         neg2_reg;
    logic [owdm_pkg::NUM_W-1:0]   rem3_reg;
    logic [1:0]                   q3_reg;
    logic                         ovf3_reg;
    logic                         neg3_reg;
    logic [owdm_pkg::NUM_W-1:0]   rem4_reg;
    logic [3:0]                   q4_reg;
    logic                         ovf4_reg;
    logic                         neg4_reg;
    logic [owdm_pkg::NUM_W-1:0]   rem5_reg;
    logic [5:0]                   q5_reg;
    logic                         ovf5_reg;
    logic                         neg5_reg;
    owdm_pkg::axis_t              axis6_reg;

    always_comb begin
        x_ext  = {stick[owdm_pkg::STICK_W-1], stick};
        dz_ext = $signed({2'b00, dead_zone});
        is_pos = x_ext > dz_ext;
        is_neg = x_ext < -dz_ext;
        if (is_pos) begin
            mag_s = x_ext - dz_ext;
        end else if (is_neg) begin
            mag_s = -dz_ext - x_ext;
        end else begin
            mag_s = '0;
        end
        den = (dead_zone == owdm_pkg::AXIS_FULL) ? 15'd1 : owdm_pkg::AXIS_FULL - dead_zone;
        num_next = {mag0_reg, 8'd0} - {8'd0, mag0_reg};
        step3 = owdm_pkg::div_step2(rem2_reg, den, 7);
        step4 = owdm_pkg::div_step2(rem3_reg, den, 5);
        step5 = owdm_pkg::div_step2(rem4_reg, den, 3);
        step6 = owdm_pkg::div_step2(rem5_reg, den, 1);
        mag_final = ovf5_reg ? owdm_pkg::DUTY_MAX : {q5_reg, step6.q};
    end

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            mag0_reg <= mag_s[owdm_pkg::STICK_W-1:0];
            neg0_reg <= is_neg;
        end
        if (stage_en[1]) begin
            num1_reg <= num_next;
            neg1_reg <= neg0_reg;
        end
        if (stage_en[2]) begin
            rem2_reg <= num1_reg;
            ovf2_reg <= num1_reg >= {1'b0, den, 8'd0};
            neg2_reg <= neg1_reg;
        end
        if (stage_en[3]) begin
            rem3_reg <= step3.rem;
            q3_reg   <= step3.q;
            ovf3_reg <= ovf2_reg;
            neg3_reg <= neg2_reg;
        end
        if (stage_en[4]) begin
            rem4_reg <= step4.rem;
            q4_reg   <= {q3_reg, step4.q};
            ovf4_reg <= ovf3_reg;
            neg4_reg <= neg3_reg;
        end
        if (stage_en[5]) begin
            rem5_reg <= step5.rem;
            q5_reg   <= {q4_reg, step5.q};
            ovf5_reg <= ovf4_reg;
            neg5_reg <= neg4_reg;
        end
        if (stage_en[6]) begin
            axis6_reg <= neg5_reg ? -$signed({1'b0, mag_final}) : $signed({1'b0, mag_final});
        end
    end

    assign axis_value = axis6_reg;

endmodule
`default_nettype wire

@@ rtl/owdm_mixer.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// owdm_mixer
// Merges the three axis lanes through the wheel matrix and forms duty and
// direction for each wheel.
// ----------------------------------------------------------------------------
module owdm_mixer (
    input  wire logic                                aclk,
    input  wire logic [owdm_pkg::MIX_STAGES-1:0]     stage_en,
    input  wire owdm_pkg::axis_t                     axis_in [owdm_pkg::AXIS_COUNT],
    input  wire owdm_pkg::row_t                      rows [owdm_pkg::WHEEL_COUNT],
    output logic [owdm_pkg::DUTY_W-1:0]              duty [owdm_pkg::WHEEL_COUNT],
    output logic                                     forward [owdm_pkg::WHEEL_COUNT]
);

    logic signed [owdm_pkg::PROD_W-1:0]
        prod_reg [owdm_pkg::WHEEL_COUNT][owdm_pkg::AXIS_COUNT];
    logic signed [owdm_pkg::SUM_W-1:0] sum_reg [owdm_pkg::WHEEL_COUNT];
    logic [owdm_pkg::DUTY_W-1:0]       duty_reg [owdm_pkg::WHEEL_COUNT];
    logic                              forward_reg [owdm_pkg::WHEEL_COUNT];

    logic signed [owdm_pkg::PROD_W-1:0]
        prod_next [owdm_pkg::WHEEL_COUNT][owdm_pkg::AXIS_COUNT];
    logic signed [owdm_pkg::SUM_W-1:0] sum_next [owdm_pkg::WHEEL_COUNT];
    logic [owdm_pkg::SUM_W-1:0]        abs_sum [owdm_pkg::WHEEL_COUNT];
    logic [owdm_pkg::DUTY_W-1:0]       duty_next [owdm_pkg::WHEEL_COUNT];
    logic                              forward_next [owdm_pkg::WHEEL_COUNT];

    always_comb begin
        for (int w = 0; w < owdm_pkg::WHEEL_COUNT; w++) begin
            for (int j = 0; j < owdm_pkg::AXIS_COUNT; j++) begin
                prod_next[w][j] = $signed(rows[w][owdm_pkg::COEF_W*j +: owdm_pkg::COEF_W])
                                  * axis_in[j];
            end
            sum_next[w] = owdm_pkg::SUM_W'(prod_reg[w][0]) + owdm_pkg::SUM_W'(prod_reg[w][1])
                          + owdm_pkg::SUM_W'(prod_reg[w][2]);
            abs_sum[w] = sum_reg[w][owdm_pkg::SUM_W-1] ? owdm_pkg::SUM_W'(-sum_reg[w])
                                                       : owdm_pkg::SUM_W'(sum_reg[w]);
            if (|abs_sum[w][owdm_pkg::SUM_W-1:16]) begin
                duty_next[w] = owdm_pkg::DUTY_MAX;
            end else begin
                duty_next[w] = abs_sum[w][15:8];
            end
            forward_next[w] = !sum_reg[w][owdm_pkg::SUM_W-1] && (sum_reg[w] != '0);
        end
    end

    always_ff @(posedge aclk) begin
        for (int w = 0; w < owdm_pkg::WHEEL_COUNT; w++) begin
            if (stage_en[0]) begin
                for (int j = 0; j < owdm_pkg::AXIS_COUNT; j++) begin
                    prod_reg[w][j] <= prod_next[w][j];
                end
            end
            if (stage_en[1]) begin
                sum_reg[w] <= sum_next[w];
            end
            if (stage_en[2]) begin
                duty_reg[w]    <= duty_next[w];
                forward_reg[w] <= forward_next[w];
            end
        end
    end

    always_comb begin
        for (int w = 0; w < owdm_pkg::WHEEL_COUNT; w++) begin
            duty[w]    = duty_reg[w];
            forward[w] = forward_reg[w];
        end
    end

endmodule
`default_nettype wire

@@ rtl/omni_wheel_drive_mixer_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// omni_wheel_drive_mixer_unit
// Three-wheel omni drive mixer: stick axes through dead zone, rescale and
// wheel matrix to per-wheel duty and direction.
// ----------------------------------------------------------------------------
// An accepted item travels to its result on the m_ side through
// seven stages of axis lane (dead zone, scale, overflow check, four divider
// steps of two quotient bits each), then products, sums and the output register.
// Throughput is one item per cycle; a stalled output holds the pipeline only
// once every stage is occupied, and empty stages fill behind it.
// A synchronous low aresetn empties the pipeline and loads the register reset
// values; no clearing pass is needed.
// ----------------------------------------------------------------------------
module omni_wheel_drive_mixer_unit (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,

    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic signed [owdm_pkg::STICK_W-1:0]  s_stick_forward,
    input  wire logic signed [owdm_pkg::STICK_W-1:0]  s_stick_strafe,
    input  wire logic signed [owdm_pkg::STICK_W-1:0]  s_stick_turn,

    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic [owdm_pkg::DUTY_W-1:0]               m_wheel1_duty,
    output logic                                      m_wheel1_forward,
    output logic [owdm_pkg::DUTY_W-1:0]               m_wheel2_duty,
    output logic                                      m_wheel2_forward,
    output logic [owdm_pkg::DUTY_W-1:0]               m_wheel3_duty,
    output logic                                      m_wheel3_forward,

    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [3:0]                           paddr,
    input  wire logic [31:0]                          pwdata,
    output logic [31:0]                               prdata,
    output logic                                      pready
);

    logic [owdm_pkg::DZ_W-1:0]        dead_zone_reg;
    owdm_pkg::row_t                   wheel_row_reg [owdm_pkg::WHEEL_COUNT];
    logic [owdm_pkg::PIPE_STAGES-1:0] vld_reg;
    logic [owdm_pkg::PIPE_STAGES-1:0] vld_next;
    logic [owdm_pkg::PIPE_STAGES-1:0] stage_en;

    logic                             cfg_write;
    logic [1:0]                       reg_sel;

    logic signed [owdm_pkg::STICK_W-1:0] stick [owdm_pkg::AXIS_COUNT];
    owdm_pkg::axis_t                     axis_value [owdm_pkg::AXIS_COUNT];
    logic [owdm_pkg::DUTY_W-1:0]         duty [owdm_pkg::WHEEL_COUNT];
    logic                                forward [owdm_pkg::WHEEL_COUNT];

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_sel   = paddr[3:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dead_zone_reg    <= owdm_pkg::DEAD_ZONE_RESET;
            wheel_row_reg[0] <= owdm_pkg::WHEEL1_ROW_RESET;
            wheel_row_reg[1] <= owdm_pkg::WHEEL2_ROW_RESET;
            wheel_row_reg[2] <= owdm_pkg::WHEEL3_ROW_RESET;
        end else if (cfg_write) begin
            unique case (reg_sel)
                owdm_pkg::REG_DEAD_ZONE: begin
                    dead_zone_reg <= pwdata[owdm_pkg::DZ_W-1:0];
                end
                owdm_pkg::REG_WHEEL1_ROW: begin
                    wheel_row_reg[0] <= pwdata[owdm_pkg::ROW_W-1:0];
                end
                owdm_pkg::REG_WHEEL2_ROW: begin
                    wheel_row_reg[1] <= pwdata[owdm_pkg::ROW_W-1:0];
                end
                owdm_pkg::REG_WHEEL3_ROW: begin
                    wheel_row_reg[2] <= pwdata[owdm_pkg::ROW_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            owdm_pkg::REG_DEAD_ZONE:  prdata = {17'd0, dead_zone_reg};
            owdm_pkg::REG_WHEEL1_ROW: prdata = {2'd0, wheel_row_reg[0]};
            owdm_pkg::REG_WHEEL2_ROW: prdata = {2'd0, wheel_row_reg[1]};
            owdm_pkg::REG_WHEEL3_ROW: prdata = {2'd0, wheel_row_reg[2]};
            default:                  prdata = '0;
        endcase
    end

    // A stage loads when it is empty or its content moves on.
    always_comb begin
        stage_en[owdm_pkg::PIPE_STAGES-1] = !vld_reg[owdm_pkg::PIPE_STAGES-1] || m_ready;
        for (int k = owdm_pkg::PIPE_STAGES-2; k >= 0; k--) begin
            stage_en[k] = !vld_reg[k] || stage_en[k+1];
        end
        for (int k = 0; k < owdm_pkg::PIPE_STAGES; k++) begin
            if (stage_en[k]) begin
                vld_next[k] = (k == 0) ? s_valid : vld_reg[(k == 0) ? 0 : k-1];
            end else begin
                vld_next[k] = vld_reg[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign s_ready = stage_en[0];
    assign m_valid = vld_reg[owdm_pkg::PIPE_STAGES-1];

    assign stick[0] = s_stick_forward;
    assign stick[1] = s_stick_strafe;
    assign stick[2] = s_stick_turn;

    for (genvar a = 0; a < owdm_pkg::AXIS_COUNT; a++) begin : g_lane
        owdm_axis_lane u_lane (
            .aclk       (aclk),
            .stage_en   (stage_en[owdm_pkg::LANE_STAGES-1:0]),
            .dead_zone  (dead_zone_reg),
            .stick      (stick[a]),
            .axis_value (axis_value[a])
        );
    end

    owdm_mixer u_mixer (
        .aclk     (aclk),
        .stage_en (stage_en[owdm_pkg::PIPE_STAGES-1:owdm_pkg::LANE_STAGES]),
        .axis_in  (axis_value),
        .rows     (wheel_row_reg),
        .duty     (duty),
        .forward  (forward)
    );

    assign m_wheel1_duty    = duty[0];
    assign m_wheel1_forward = forward[0];
    assign m_wheel2_duty    = duty[1];
    assign m_wheel2_forward = forward[1];
    assign m_wheel3_duty    = duty[2];
    assign m_wheel3_forward = forward[2];

    // An empty or draining output stage lets every earlier stage move.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid || m_ready) |-> s_ready)
        else $error("input stalled although the output stage can move");

    // Input backpressure only arises with every stage occupied.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (&vld_reg))
        else $error("input stalled with a bubble in the pipeline");

    // Reset empties the pipeline.
    assert property (@(posedge aclk)
        !aresetn |=> (vld_reg == '0))
        else $error("pipeline not empty after reset");

    // A result stalled at the output leaves the pipeline occupancy unchanged.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (!s_ready && !s_valid) |=> (&vld_reg))
        else $error("pipeline lost an item while stalled");

endmodule
`default_nettype wire
